FILE: design/tmsc_pkg.sv
// ----------------------------------------------------------------------------
// tmsc_pkg
// Shared constants and types of the temporal mean filter (centre frame skipped).
// ----------------------------------------------------------------------------
package tmsc_pkg;

    localparam int NUM_CH               = 3;
    localparam int PIX_W                = 8;
    localparam int PIX_MAX              = 255;
    localparam int CFG_WIN_W            = 4;
    localparam int CFG_FP_W             = 17;
    localparam int CFG_DATA_W           = 17;
    localparam int CFG_IDX_W            = 2;
    localparam int MIN_WINDOW           = 3;
    localparam int WIN_RESET            = 3;
    localparam int DEF_MAX_WINDOW       = 8;
    localparam int DEF_MAX_FRAME_PIXELS = 65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LEN   = 2'd0,
        REG_FRAME_PIXELS = 2'd1
    } tmsc_reg_t;

    // channel 0 blue, 1 green, 2 red
    typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_t;

    typedef struct packed {
        logic first;   // no frame held yet: stored sums read as zero
        logic full;    // window full: this pixel yields a result
        logic last;    // last pixel of the frame
    } tmsc_ctl_t;

    typedef struct packed {
        logic frame_end;
        pix_t mean;
    } tmsc_res_t;

endpackage

FILE: design/tmsc_ram.sv
// ----------------------------------------------------------------------------
// tmsc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmsc_ram import tmsc_pkg::*; #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/tmsc_div.sv
// ----------------------------------------------------------------------------
// tmsc_div
// Pipelined restoring divider, one quotient bit per stage, three lanes with a
// shared divisor, followed by a round-to-nearest-even and saturate stage.
// ----------------------------------------------------------------------------
module tmsc_div import tmsc_pkg::*; #(
    parameter int DVD_W = 11,
    parameter int DVS_W = 4,
    parameter int TAG_W = 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [NUM_CH-1:0][DVD_W-1:0]  in_dvd,
    input  logic [TAG_W-1:0]              in_tag,
    input  logic [DVS_W-1:0]              divisor,
    output logic                          out_valid,
    output pix_t                          out_mean,
    output logic [TAG_W-1:0]              out_tag
);

    localparam int AW = DVS_W + 1 + DVD_W;

    typedef logic [NUM_CH-1:0][AW-1:0] acc_t;

    logic [DVD_W-1:0] vld_reg;
    acc_t             acc_reg  [DVD_W];
    acc_t             acc_next [DVD_W];
    logic [TAG_W-1:0] tag_reg  [DVD_W];

    logic             rnd_valid_reg;
    pix_t             rnd_mean_reg;
    pix_t             rnd_mean_next;
    logic [TAG_W-1:0] rnd_tag_reg;

    // {remainder, dividend/quotient}: shift, trial subtract, set quotient bit
    function automatic logic [AW-1:0] div_step(logic [AW-1:0] a, logic [DVS_W-1:0] d);
        logic [AW-1:0] t;
        logic [DVS_W:0] hi;
        t  = a << 1;
        hi = t[AW-1:DVD_W];
        if (hi >= {1'b0, d}) begin
            t[AW-1:DVD_W] = hi - {1'b0, d};
            t[0]          = 1'b1;
        end
        return t;
    endfunction

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            acc_next[0][c] = div_step({{(DVS_W+1){1'b0}}, in_dvd[c]}, divisor);
            for (int i = 1; i < DVD_W; i++) begin
                acc_next[i][c] = div_step(acc_reg[i-1][c], divisor);
            end
        end
    end

    always_comb begin
        logic [DVD_W-1:0] q;
        logic [DVS_W:0]   r;
        logic [DVS_W+1:0] r2;
        logic [DVS_W+1:0] dd;
        logic             up;
        logic [DVD_W:0]   qr;
        for (int c = 0; c < NUM_CH; c++) begin
            q  = acc_reg[DVD_W-1][c][DVD_W-1:0];
            r  = acc_reg[DVD_W-1][c][AW-1:DVD_W];
            r2 = {r, 1'b0};
            dd = (DVS_W+2)'(divisor);
            up = (r2 > dd) || ((r2 == dd) && q[0]);
            qr = {1'b0, q} + (DVD_W+1)'(up);
            rnd_mean_next[c] = (qr > (DVD_W+1)'(PIX_MAX)) ? PIX_W'(PIX_MAX) : qr[PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            rnd_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg       <= {vld_reg[DVD_W-2:0], in_valid};
            rnd_valid_reg <= vld_reg[DVD_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= in_tag;
            for (int i = 0; i < DVD_W; i++) begin
                acc_reg[i] <= acc_next[i];
            end
            for (int i = 1; i < DVD_W; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
            rnd_mean_reg <= rnd_mean_next;
            rnd_tag_reg  <= tag_reg[DVD_W-1];
        end
    end

    assign out_valid = rnd_valid_reg;
    assign out_mean  = rnd_mean_reg;
    assign out_tag   = rnd_tag_reg;

endmodule

FILE: design/tmsc_ctrl.sv
// ----------------------------------------------------------------------------
// tmsc_ctrl
// Configuration registers, raster position, frame count and slot rotation.
// Produces store addresses and per-pixel control for the pixel being taken.
// ----------------------------------------------------------------------------
module tmsc_ctrl import tmsc_pkg::*; #(
    parameter  int MAX_WINDOW       = DEF_MAX_WINDOW,
    parameter  int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS,
    localparam int POS_W            = $clog2(MAX_FRAME_PIXELS),
    localparam int WIN_W            = $clog2(MAX_WINDOW + 1),
    localparam int SLOT_W           = $clog2(MAX_WINDOW)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  accept,
    output logic [POS_W-1:0]      pos,
    output logic [SLOT_W-1:0]     centre_slot,
    output logic [SLOT_W-1:0]     oldest_slot,
    output logic [SLOT_W-1:0]     wr_slot,
    output logic [WIN_W-1:0]      divisor,
    output tmsc_ctl_t             ctl
);

    localparam int CW  = (WIN_W > CFG_WIN_W) ? WIN_W : CFG_WIN_W;
    localparam int FPW = POS_W + 1;
    localparam int FW  = (FPW > CFG_FP_W) ? FPW : CFG_FP_W;

    logic [WIN_W-1:0]  win_reg,    win_next;
    logic [FPW-1:0]    fp_reg,     fp_next;
    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic [WIN_W-1:0]  held_reg,   held_next;
    logic [SLOT_W-1:0] oldest_reg, oldest_next;

    logic [CW-1:0]     cw;
    logic [WIN_W-1:0]  win_cfg;
    logic [FW-1:0]     fpc;
    logic [FPW-1:0]    fp_cfg;
    logic [WIN_W:0]    csum;
    logic [WIN_W:0]    fsum;
    logic [SLOT_W-1:0] fill_slot;
    logic [WIN_W-1:0]  oldest_inc;

    // clamp register values into their working ranges
    always_comb begin
        cw  = CW'(cfg_wdata[CFG_WIN_W-1:0]);
        fpc = FW'(cfg_wdata[CFG_FP_W-1:0]);
        priority if (cw < CW'(MIN_WINDOW)) begin
            win_cfg = WIN_W'(MIN_WINDOW);
        end else if (cw > CW'(MAX_WINDOW)) begin
            win_cfg = WIN_W'(MAX_WINDOW);
        end else begin
            win_cfg = WIN_W'(cw);
        end
        priority if (fpc == '0) begin
            fp_cfg = FPW'(1);
        end else if (fpc > FW'(MAX_FRAME_PIXELS)) begin
            fp_cfg = FPW'(MAX_FRAME_PIXELS);
        end else begin
            fp_cfg = FPW'(fpc);
        end
    end

    always_comb begin
        ctl.full  = (held_reg == win_reg);
        ctl.first = (held_reg == '0);
        ctl.last  = ({1'b0, pos_reg} + FPW'(1)) == fp_reg;

        csum = (WIN_W+1)'(oldest_reg) + (WIN_W+1)'(win_reg >> 1);
        if (csum >= (WIN_W+1)'(win_reg)) begin
            csum = csum - (WIN_W+1)'(win_reg);
        end
        fsum = (WIN_W+1)'(oldest_reg) + (WIN_W+1)'(held_reg);
        if (fsum >= (WIN_W+1)'(win_reg)) begin
            fsum = fsum - (WIN_W+1)'(win_reg);
        end
        centre_slot = SLOT_W'(csum);
        fill_slot   = SLOT_W'(fsum);
        oldest_slot = oldest_reg;
        wr_slot     = ctl.full ? oldest_reg : fill_slot;
        pos         = pos_reg;
        divisor     = win_reg - WIN_W'(1);
        oldest_inc  = WIN_W'(oldest_reg) + WIN_W'(1);
    end

    always_comb begin
        win_next    = win_reg;
        fp_next     = fp_reg;
        pos_next    = pos_reg;
        held_next   = held_reg;
        oldest_next = oldest_reg;
        if (cfg_wr_en) begin
            unique case (tmsc_reg_t'(cfg_index))
                REG_WINDOW_LEN: begin
                    win_next    = win_cfg;
                    pos_next    = '0;
                    held_next   = '0;
                    oldest_next = '0;
                end
                REG_FRAME_PIXELS: begin
                    fp_next     = fp_cfg;
                    pos_next    = '0;
                    held_next   = '0;
                    oldest_next = '0;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (ctl.last) begin
                pos_next = '0;
                if (!ctl.full) begin
                    held_next = held_reg + WIN_W'(1);
                end else if (oldest_inc == win_reg) begin
                    oldest_next = '0;
                end else begin
                    oldest_next = SLOT_W'(oldest_inc);
                end
            end else begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg    <= WIN_W'(WIN_RESET);
            fp_reg     <= FPW'(MAX_FRAME_PIXELS);
            pos_reg    <= '0;
            held_reg   <= '0;
            oldest_reg <= '0;
        end else begin
            win_reg    <= win_next;
            fp_reg     <= fp_next;
            pos_reg    <= pos_next;
            held_reg   <= held_next;
            oldest_reg <= oldest_next;
        end
    end

`ifndef SYNTH
    a_oldest_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        WIN_W'(oldest_reg) < win_reg)
        else $error("oldest slot outside window");
    a_held_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= win_reg)
        else $error("frame count exceeds window");
    a_fill_no_rotate: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_reg != win_reg) |-> (oldest_reg == '0))
        else $error("slot rotation before window full");
`endif

endmodule

FILE: design/temporal_mean_skip_center.sv
// ----------------------------------------------------------------------------
// temporal_mean_skip_center
// Temporal mean over the last N frames of an RGB raster, centre frame left
// out, rounded to nearest even. Frame store and per-pixel running sums in RAM.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction | transfer
//  --------+-----------------------------------------+-----------+----------------
//  input   | s_valid s_ready s_pix_blue/green/red    | in        | s_valid&s_ready
//  result  | m_valid m_ready m_mean_blue/green/red,  | out       | m_valid&m_ready
//          | m_frame_end                             |           |
//  config  | cfg_wr_en cfg_index cfg_wdata           | in        | cfg_wr_en
//
//  One pixel per cycle while the skid entry is free. Each result passes
//  through these steps: the store read overlaps the input transfer, then one
//  divider stage per sum bit, a rounding stage and the output register.
//  No result while the first N frames fill.
//  No clearing pass: sums read as zero while the first frame is written.
//  A stalled result is held with one skid entry; input stops once it is used.
// ----------------------------------------------------------------------------
module temporal_mean_skip_center import tmsc_pkg::*; #(
    parameter int MAX_WINDOW       = DEF_MAX_WINDOW,
    parameter int MAX_FRAME_PIXELS = DEF_MAX_FRAME_PIXELS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_pix_blue,
    input  logic [PIX_W-1:0]      s_pix_green,
    input  logic [PIX_W-1:0]      s_pix_red,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_mean_blue,
    output logic [PIX_W-1:0]      m_mean_green,
    output logic [PIX_W-1:0]      m_mean_red,
    output logic                  m_frame_end
);

    localparam int POS_W      = $clog2(MAX_FRAME_PIXELS);
    localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int SUM_W      = $clog2(MAX_WINDOW * PIX_MAX + 1);
    localparam int RING_AW    = SLOT_W + POS_W;
    localparam int RING_DEPTH = MAX_WINDOW << POS_W;

    typedef logic [NUM_CH-1:0][SUM_W-1:0] sums_t;

    logic              adv;
    logic              accept;
    logic [POS_W-1:0]  pos;
    logic [SLOT_W-1:0] centre_slot;
    logic [SLOT_W-1:0] oldest_slot;
    logic [SLOT_W-1:0] wr_slot;
    logic [WIN_W-1:0]  divisor;
    tmsc_ctl_t         ctl;

    logic [RING_AW-1:0] ring_c_raddr;
    logic [RING_AW-1:0] ring_o_raddr;
    logic [RING_AW-1:0] ring_waddr;
    pix_t               ring_c_rdata;
    pix_t               ring_o_rdata;
    sums_t              sums_rdata;
    logic               store_we;

    logic              b_valid_reg, b_valid_next;
    logic              b_fwd_reg,   b_fwd_next;
    pix_t              b_pix_reg;
    logic [POS_W-1:0]  b_pos_reg;
    logic [SLOT_W-1:0] b_wslot_reg;
    tmsc_ctl_t         b_ctl_reg;
    sums_t             last_wr_reg;

    sums_t             s_cur;
    sums_t             s_new;
    sums_t             part;

    logic              div_valid;
    pix_t              div_mean;
    logic              div_last;
    logic              arrive;
    logic              take;

    logic              m_valid_reg,    m_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    tmsc_res_t         m_data_reg,     m_data_next;
    tmsc_res_t         skid_data_reg,  skid_data_next;

    assign adv     = !skid_valid_reg;
    assign s_ready = adv;
    assign accept  = s_valid && adv;

    tmsc_ctrl #(
        .MAX_WINDOW       (MAX_WINDOW),
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .pos         (pos),
        .centre_slot (centre_slot),
        .oldest_slot (oldest_slot),
        .wr_slot     (wr_slot),
        .divisor     (divisor),
        .ctl         (ctl)
    );

    // frame store kept as two identical banks, one read port each
    assign ring_c_raddr = {centre_slot, pos};
    assign ring_o_raddr = {oldest_slot, pos};
    assign ring_waddr   = {b_wslot_reg, b_pos_reg};
    assign store_we     = b_valid_reg && adv;

    tmsc_ram #(.WIDTH(NUM_CH * PIX_W), .DEPTH(RING_DEPTH)) u_ring_c (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (ring_waddr),
        .wdata (b_pix_reg),
        .re    (adv),
        .raddr (ring_c_raddr),
        .rdata (ring_c_rdata)
    );

    tmsc_ram #(.WIDTH(NUM_CH * PIX_W), .DEPTH(RING_DEPTH)) u_ring_o (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (ring_waddr),
        .wdata (b_pix_reg),
        .re    (adv),
        .raddr (ring_o_raddr),
        .rdata (ring_o_rdata)
    );

    tmsc_ram #(.WIDTH(NUM_CH * SUM_W), .DEPTH(MAX_FRAME_PIXELS)) u_sums (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (b_pos_reg),
        .wdata (s_new),
        .re    (adv),
        .raddr (pos),
        .rdata (sums_rdata)
    );

    // read stage: capture pixel and control while the stores are read
    always_comb begin
        b_valid_next = accept;
        b_fwd_next   = accept && b_valid_reg && (b_pos_reg == pos);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_fwd_reg   <= b_fwd_next;
            b_pix_reg   <= {s_pix_red, s_pix_green, s_pix_blue};
            b_pos_reg   <= pos;
            b_wslot_reg <= wr_slot;
            b_ctl_reg   <= ctl;
        end
        if (store_we) begin
            last_wr_reg <= s_new;
        end
    end

    // update stage: pick zero, forwarded or stored sum; form new sum and centre-free part
    always_comb begin
        logic [SUM_W-1:0] cv;
        logic [SUM_W-1:0] ov;
        logic [SUM_W-1:0] base;
        for (int c = 0; c < NUM_CH; c++) begin
            priority if (b_ctl_reg.first) begin
                s_cur[c] = '0;
            end else if (b_fwd_reg) begin
                s_cur[c] = last_wr_reg[c];
            end else begin
                s_cur[c] = sums_rdata[c];
            end
            cv      = SUM_W'(ring_c_rdata[c]);
            ov      = SUM_W'(ring_o_rdata[c]);
            part[c] = (s_cur[c] >= cv) ? s_cur[c] - cv : '0;
            if (b_ctl_reg.full) begin
                base = (s_cur[c] >= ov) ? s_cur[c] - ov : '0;
            end else begin
                base = s_cur[c];
            end
            s_new[c] = base + SUM_W'(b_pix_reg[c]);
        end
    end

    tmsc_div #(
        .DVD_W (SUM_W),
        .DVS_W (WIN_W),
        .TAG_W (1)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (b_valid_reg && b_ctl_reg.full),
        .in_dvd    (part),
        .in_tag    (b_ctl_reg.last),
        .divisor   (divisor),
        .out_valid (div_valid),
        .out_mean  (div_mean),
        .out_tag   (div_last)
    );

    // output register with one skid entry
    assign arrive = adv && div_valid;
    assign take   = m_valid_reg && m_ready;

    always_comb begin
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        m_data_next     = m_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (take) begin
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (!m_valid_reg || take) begin
            m_valid_next          = arrive;
            m_data_next.mean      = div_mean;
            m_data_next.frame_end = div_last;
        end else if (arrive) begin
            skid_valid_next          = 1'b1;
            skid_data_next.mean      = div_mean;
            skid_data_next.frame_end = div_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_mean_blue  = m_data_reg.mean[0];
    assign m_mean_green = m_data_reg.mean[1];
    assign m_mean_red   = m_data_reg.mean[2];
    assign m_frame_end  = m_data_reg.frame_end;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry without output entry");
    a_fwd_after_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && b_fwd_reg) |-> !b_ctl_reg.first)
        else $error("sum forwarded during first frame");
    a_ring_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ctl.full && b_valid_reg && (b_pos_reg == pos)) |->
        ((b_wslot_reg != centre_slot) && (b_wslot_reg != oldest_slot)))
        else $error("frame store read hits slot being written");
`endif

endmodule
